@@ design/ecl_pkg.sv @@
`default_nettype none
package ecl_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned EpsQ       = 655;

  localparam logic [1:0] AxisZ = 2'd2;
  localparam logic [1:0] AxisW = 2'd3;

  // Control that travels with one item through a divider pass.
  typedef struct packed {
    logic       vld;
    logic       vis;
    logic       cut;
    logic       cut_p;
  } ctl_t;

endpackage
`default_nettype wire

@@ design/ecl_divstep.sv @@
`default_nettype none
// One registered step of a restoring division: retires DPS quotient bits for
// each of four lanes that share one denominator.
module ecl_divstep #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 33,
  parameter int unsigned DPS  = 4,
  parameter int unsigned PayW = 8
) (
  input  wire              clk_i,
  input  wire              en_i,
  input  wire  [DenW-1:0]  den_i,
  input  wire  [NumW-1:0]  num_i [4],
  input  wire  [DenW:0]    rem_i [4],
  input  wire  [PayW-1:0]  pay_i,
  output logic [DenW-1:0]  den_o,
  output logic [NumW-1:0]  num_o [4],
  output logic [DenW:0]    rem_o [4],
  output logic [PayW-1:0]  pay_o
);

  logic [NumW-1:0] num_d [4];
  logic [DenW:0]   rem_d [4];

  always_comb begin
    logic [DenW+1:0] tr;
    for (int l = 0; l < 4; l++) begin
      num_d[l] = num_i[l];
      rem_d[l] = rem_i[l];
      for (int s = 0; s < int'(DPS); s++) begin
        tr = {rem_d[l], num_d[l][NumW-1]};
        num_d[l] = {num_d[l][NumW-2:0], 1'b0};
        if (tr >= {2'b00, den_i}) begin
          tr = tr - {2'b00, den_i};
          num_d[l][0] = 1'b1;
        end
        rem_d[l] = tr[DenW:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o <= den_i;
      num_o <= num_d;
      rem_o <= rem_d;
      pay_o <= pay_i;
    end
  end

endmodule
`default_nettype wire

@@ design/ecl_pass.sv @@
`default_nettype none
// One clipping pass on axis Axis: classify, form |b|*|p-q|, divide in a
// chain of registered steps, then apply the sign and force the epsilon.
module ecl_pass #(
  parameter int unsigned        CW   = ecl_pkg::CoordWidth,
  parameter logic [1:0]         Axis = ecl_pkg::AxisW
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   en_i,
  input  wire  ecl_pkg::ctl_t   ctl_i,
  input  wire  signed [CW-1:0]  p_i [4],
  input  wire  signed [CW-1:0]  q_i [4],
  output ecl_pkg::ctl_t         ctl_o,
  output logic signed [CW-1:0]  p_o [4],
  output logic signed [CW-1:0]  q_o [4]
);

  localparam int unsigned DenW  = CW + 1;
  localparam int unsigned NumW  = 2 * CW + 1;
  localparam int unsigned DPS   = 4;
  localparam int unsigned Steps = (NumW + DPS - 1) / DPS;
  localparam int unsigned NumP  = Steps * DPS;
  localparam int unsigned PayW  = 3 + 8 * CW + 4;

  // Stage 1: classification, magnitudes, differences and the denominator.
  logic signed [CW-1:0] a, b;
  logic                 cls_cut, cls_cut_p, cls_vis;
  assign a = p_i[Axis];
  assign b = q_i[Axis];
  always_comb begin
    cls_vis   = ctl_i.vis;
    cls_cut   = 1'b0;
    cls_cut_p = 1'b0;
    if (ctl_i.vis) begin
      if (a < 0) begin
        if (b <= 0) cls_vis = 1'b0;
        else begin
          cls_cut = 1'b1;
          cls_cut_p = 1'b1;
        end
      end else if (b < 0) begin
        cls_cut = 1'b1;
      end
    end
  end

  logic [CW-1:0]   nb, na;
  assign nb = b[CW-1] ? CW'(-b) : CW'(b);
  assign na = a[CW-1] ? CW'(-a) : CW'(a);

  ecl_pkg::ctl_t        s1_ctl_q;
  logic signed [CW-1:0] s1_p_q [4], s1_q_q [4];
  logic [CW-1:0]        s1_nb_q;
  logic [CW:0]          s1_d_q [4];
  logic [3:0]           s1_ge_q;
  logic [DenW-1:0]      s1_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_ctl_q <= '0;
    else if (en_i) s1_ctl_q <= '{vld: ctl_i.vld, vis: cls_vis, cut: cls_cut,
                                 cut_p: cls_cut_p};
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_p_q   <= p_i;
      s1_q_q   <= q_i;
      s1_nb_q  <= nb;
      s1_den_q <= {1'b0, na} + {1'b0, nb};
      for (int i = 0; i < 4; i++) begin
        s1_ge_q[i] <= (p_i[i] >= q_i[i]);
        s1_d_q[i]  <= (p_i[i] >= q_i[i])
                      ? ({p_i[i][CW-1], p_i[i]} - {q_i[i][CW-1], q_i[i]})
                      : ({q_i[i][CW-1], q_i[i]} - {p_i[i][CW-1], p_i[i]});
      end
    end
  end

  // Stage 2: product plus half the denominator.
  ecl_pkg::ctl_t   s2_ctl_q;
  logic [PayW-1:0] s2_pay_q;
  logic [NumP-1:0] s2_num_q [4];
  logic [DenW-1:0] s2_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_ctl_q <= '0;
    else if (en_i) s2_ctl_q <= s1_ctl_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_den_q <= s1_den_q;
      for (int i = 0; i < 4; i++)
        s2_num_q[i] <= NumP'(s1_nb_q) * NumP'(s1_d_q[i]) + NumP'(s1_den_q >> 1);
      s2_pay_q <= {s1_ctl_q.vis, s1_ctl_q.cut, s1_ctl_q.cut_p, s1_ge_q,
                   s1_p_q[0], s1_p_q[1], s1_p_q[2], s1_p_q[3],
                   s1_q_q[0], s1_q_q[1], s1_q_q[2], s1_q_q[3]};
    end
  end

  // Divider chain; valid bits march beside it.
  logic [DenW-1:0] den_c [Steps+1];
  logic [NumP-1:0] num_c [Steps+1][4];
  logic [DenW:0]   rem_c [Steps+1][4];
  logic [PayW-1:0] pay_c [Steps+1];
  logic [Steps:0]  vld_c;

  assign den_c[0] = s2_den_q;
  assign num_c[0] = s2_num_q;
  assign pay_c[0] = s2_pay_q;
  assign vld_c[0] = s2_ctl_q.vld;
  always_comb for (int l = 0; l < 4; l++) rem_c[0][l] = '0;

  for (genvar g = 0; g < Steps; g++) begin : g_div
    ecl_divstep #(.NumW(NumP), .DenW(DenW), .DPS(DPS), .PayW(PayW)) u_step (
      .clk_i, .en_i,
      .den_i(den_c[g]), .num_i(num_c[g]), .rem_i(rem_c[g]), .pay_i(pay_c[g]),
      .den_o(den_c[g+1]), .num_o(num_c[g+1]), .rem_o(rem_c[g+1]),
      .pay_o(pay_c[g+1])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_c[g+1] <= 1'b0;
      else if (en_i) vld_c[g+1] <= vld_c[g];
    end
  end

  // Final stage: rebuild the crossing point and choose the endpoints.
  logic [PayW-1:0]      fp;
  logic                 f_vis, f_cut, f_cutp;
  logic [3:0]           f_ge;
  logic signed [CW-1:0] f_p [4], f_q [4], x_pt [4], np [4], nq [4];
  assign fp = pay_c[Steps];
  assign {f_vis, f_cut, f_cutp, f_ge,
          f_p[0], f_p[1], f_p[2], f_p[3],
          f_q[0], f_q[1], f_q[2], f_q[3]} = fp;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      x_pt[i] = f_ge[i] ? (f_q[i] + CW'(num_c[Steps][i]))
                        : (f_q[i] - CW'(num_c[Steps][i]));
      np[i] = f_p[i];
      nq[i] = f_q[i];
    end
    x_pt[Axis] = CW'(ecl_pkg::EpsQ);
    if (f_cut) begin
      if (f_cutp) np = x_pt;
      else nq = x_pt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ctl_o <= '0;
    else if (en_i) ctl_o <= '{vld: vld_c[Steps], vis: f_vis, cut: f_cut,
                              cut_p: f_cutp};
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= np;
      q_o <= nq;
    end
  end

endmodule
`default_nettype wire

@@ design/edge_clip_two_planes_core.sv @@
`default_nettype none
// Channel | Direction | Handshake            | Payload
// input   | in        | in_valid_i/in_stall_o   | a_*_i, b_*_i
// output  | out       | out_valid_o/out_stall_i | visible_o, c_*_o, d_*_o
//
// One item enters per cycle while in_stall_o is low. The pipeline is two
// clipping passes, each of three stages plus ceil((2*COORD_WIDTH+1)/4)
// divider steps, plus one output stage. Reset clears only the valid bits and
// the control beside them. The whole pipeline advances together; a full output
// register holds while out_stall_i is high, and the input stalls with it.
module edge_clip_two_planes_core #(
  parameter int unsigned COORD_WIDTH = ecl_pkg::CoordWidth
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  signed [COORD_WIDTH-1:0] a_x_i, a_y_i, a_z_i, a_w_i,
  input  wire  signed [COORD_WIDTH-1:0] b_x_i, b_y_i, b_z_i, b_w_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         visible_o,
  output logic signed [COORD_WIDTH-1:0] c_x_o, c_y_o, c_z_o, c_w_o,
  output logic signed [COORD_WIDTH-1:0] d_x_o, d_y_o, d_z_o, d_w_o
);

  localparam int unsigned CW = COORD_WIDTH;

  logic en;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  ecl_pkg::ctl_t        c0, c1, c2;
  logic signed [CW-1:0] p0 [4], q0 [4], p1 [4], q1 [4], p2 [4], q2 [4];

  assign c0 = '{vld: in_valid_i, vis: 1'b1, cut: 1'b0, cut_p: 1'b0};
  assign p0 = '{a_x_i, a_y_i, a_z_i, a_w_i};
  assign q0 = '{b_x_i, b_y_i, b_z_i, b_w_i};

  ecl_pass #(.CW(CW), .Axis(ecl_pkg::AxisW)) u_pass_w (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(c0), .p_i(p0), .q_i(q0),
    .ctl_o(c1), .p_o(p1), .q_o(q1)
  );
  ecl_pass #(.CW(CW), .Axis(ecl_pkg::AxisZ)) u_pass_z (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(c1), .p_i(p1), .q_i(q1),
    .ctl_o(c2), .p_o(p2), .q_o(q2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (en) out_valid_o <= c2.vld;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      visible_o <= c2.vis;
      {c_x_o, c_y_o, c_z_o, c_w_o} <= c2.vis ? {p2[0], p2[1], p2[2], p2[3]} : '0;
      {d_x_o, d_y_o, d_z_o, d_w_o} <= c2.vis ? {q2[0], q2[1], q2[2], q2[3]} : '0;
    end
  end

  a_invis_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !visible_o |-> c_w_o == '0 && d_w_o == '0 && c_z_o == '0)
    else $error("invisible item with nonzero coordinates");
  a_vis_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && visible_o |-> !c_w_o[CW-1] && !d_w_o[CW-1])
    else $error("visible item behind the w plane");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(visible_o))
    else $error("stalled output changed");

endmodule
`default_nettype wire
